/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the quantize and pack unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* hw/rtl/zlq_pkg.sv */
// Package: constants, types and the zigzag table of the quantize and pack unit.
`timescale 1ns / 1ps
package zlq_pkg;

  localparam int LEVEL_BITS        = 16;
  localparam int NUM_LEVELS        = 4;
  localparam int LEVEL_IDX_BITS    = 2;
  localparam int CODE_BITS         = 2;
  localparam int BLOCK_SIZE        = 16;
  localparam int ZZ_BITS           = 4;
  localparam int BLOCK_BITS        = BLOCK_SIZE * CODE_BITS;
  localparam int BYTES_PER_BLOCK   = 4;
  localparam int BYTE_IDX_BITS     = 2;
  localparam int QUEUE_DEPTH       = 2;
  localparam int COEF_BITS_DEFAULT = 16;
  localparam int CFG_INDEX_BITS    = 2;

  localparam logic [ZZ_BITS-1:0]        LAST_POS      = 4'd15;
  localparam logic [BYTE_IDX_BITS-1:0]  LAST_BYTE     = 2'd3;
  localparam logic [CODE_BITS-1:0]      CODE_MAX      = 2'b11;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_0 = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_1 = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_3 = 2'd3;

  localparam logic signed [LEVEL_BITS-1:0] LEVEL_0_RESET = -16'sd384;
  localparam logic signed [LEVEL_BITS-1:0] LEVEL_1_RESET = -16'sd128;
  localparam logic signed [LEVEL_BITS-1:0] LEVEL_2_RESET = 16'sd128;
  localparam logic signed [LEVEL_BITS-1:0] LEVEL_3_RESET = 16'sd384;

  // One finished block handed from the front to the queue.
  typedef struct packed {
    logic                  push;
    logic [BLOCK_BITS-1:0] word;
  } blk_push_t;

  // Raster index (row * 4 + col) to zigzag index.
  function automatic logic [ZZ_BITS-1:0] raster_to_zz(input logic [ZZ_BITS-1:0] pos);
    logic [ZZ_BITS-1:0] zz;
    unique case (pos)
      4'd0:    zz = 4'd0;
      4'd1:    zz = 4'd1;
      4'd2:    zz = 4'd5;
      4'd3:    zz = 4'd6;
      4'd4:    zz = 4'd2;
      4'd5:    zz = 4'd4;
      4'd6:    zz = 4'd7;
      4'd7:    zz = 4'd12;
      4'd8:    zz = 4'd3;
      4'd9:    zz = 4'd8;
      4'd10:   zz = 4'd11;
      4'd11:   zz = 4'd13;
      4'd12:   zz = 4'd9;
      4'd13:   zz = 4'd10;
      4'd14:   zz = 4'd14;
      default: zz = 4'd15;
    endcase
    return zz;
  endfunction

endpackage

/* hw/rtl/zlq_front.sv */
// Front end: level registers, two-stage quantizer and zigzag code store.
`timescale 1ns / 1ps
module zlq_front #(
  parameter int COEF_BITS = zlq_pkg::COEF_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [zlq_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic signed [zlq_pkg::LEVEL_BITS-1:0] cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COEF_BITS-1:0]           coef_value,
  input  logic                                  q_full,
  output zlq_pkg::blk_push_t                    blk_push
);

  localparam int VW = ((COEF_BITS > zlq_pkg::LEVEL_BITS) ? COEF_BITS : zlq_pkg::LEVEL_BITS) + 2;

  logic signed [zlq_pkg::LEVEL_BITS-1:0] level [zlq_pkg::NUM_LEVELS];
  logic [zlq_pkg::ZZ_BITS-1:0]           pos;
  logic [zlq_pkg::CODE_BITS-1:0]         code_store [zlq_pkg::BLOCK_SIZE];

  logic                                  s1_valid;
  logic signed [VW-1:0]                  s1_v;
  logic signed [zlq_pkg::LEVEL_BITS-1:0] s1_lo_lvl;
  logic signed [zlq_pkg::LEVEL_BITS-1:0] s1_hi_lvl;
  logic [zlq_pkg::LEVEL_IDX_BITS-1:0]    s1_lo_idx;
  logic [zlq_pkg::ZZ_BITS-1:0]           s1_zz;
  logic                                  s1_last;

  logic signed [VW-1:0]                  v_in;
  logic                                  above_1;
  logic                                  above_2;
  logic                                  in_xfer;
  logic                                  s1_adv;
  logic signed [VW-1:0]                  diff_lo;
  logic signed [VW-1:0]                  diff_hi;
  logic [zlq_pkg::CODE_BITS-1:0]         code;

  always_ff @(posedge clk) begin
    if (rst) begin
      level[0] <= zlq_pkg::LEVEL_0_RESET;
      level[1] <= zlq_pkg::LEVEL_1_RESET;
      level[2] <= zlq_pkg::LEVEL_2_RESET;
      level[3] <= zlq_pkg::LEVEL_3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        zlq_pkg::REG_LEVEL_0: level[0] <= cfg_data;
        zlq_pkg::REG_LEVEL_1: level[1] <= cfg_data;
        zlq_pkg::REG_LEVEL_2: level[2] <= cfg_data;
        default:              level[3] <= cfg_data;
      endcase
    end
  end

  // Stage 1: binary search for the bracketing pair.
  assign v_in    = VW'(coef_value);
  assign above_1 = VW'(level[1]) < v_in;
  assign above_2 = VW'(level[2]) < v_in;
  assign s1_adv   = s1_valid && !(s1_last && q_full);
  assign in_ready = !s1_valid || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        pos <= pos + 1'b1;
      end
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_v    <= v_in;
      s1_zz   <= zlq_pkg::raster_to_zz(pos);
      s1_last <= (pos == zlq_pkg::LAST_POS);
      priority if (above_1 && above_2) begin
        s1_lo_idx <= 2'd2;
        s1_lo_lvl <= level[2];
        s1_hi_lvl <= level[3];
      end else if (above_1) begin
        s1_lo_idx <= 2'd1;
        s1_lo_lvl <= level[1];
        s1_hi_lvl <= level[2];
      end else begin
        s1_lo_idx <= 2'd0;
        s1_lo_lvl <= level[0];
        s1_hi_lvl <= level[1];
      end
    end
  end

  // Stage 2: lower level wins only when strictly nearer.
  assign diff_lo = s1_v - VW'(s1_lo_lvl);
  assign diff_hi = VW'(s1_hi_lvl) - s1_v;
  assign code    = (diff_lo < diff_hi) ? s1_lo_idx : (s1_lo_idx + 1'b1);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      code_store[s1_zz] <= code & zlq_pkg::CODE_MAX;
    end
  end

  // Merge the final code so the block leaves in the same cycle it completes.
  always_comb begin
    blk_push.push = s1_adv && s1_last;
    for (int i = 0; i < zlq_pkg::BLOCK_SIZE; i++) begin
      blk_push.word[i*zlq_pkg::CODE_BITS +: zlq_pkg::CODE_BITS] =
        (s1_zz == zlq_pkg::ZZ_BITS'(i)) ? code : code_store[i];
    end
  end

endmodule

/* hw/rtl/zlq_queue.sv */
// Short block queue between the front end and the byte emitter.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module zlq_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  zlq_pkg::blk_push_t             blk_push,
  output logic                           full,
  output logic                           q_valid,
  output logic [zlq_pkg::BLOCK_BITS-1:0] q_word,
  input  logic                           pop
);

  localparam int PTR_BITS = (zlq_pkg::QUEUE_DEPTH > 1) ? $clog2(zlq_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(zlq_pkg::QUEUE_DEPTH + 1);

  logic [zlq_pkg::BLOCK_BITS-1:0] mem [zlq_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]            wr_ptr;
  logic [PTR_BITS-1:0]            rd_ptr;
  logic [CNT_BITS-1:0]            count;

  assign full    = (count == CNT_BITS'(zlq_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (blk_push.push) begin
      mem[wr_ptr] <= blk_push.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (blk_push.push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(zlq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(zlq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({blk_push.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_push_full, clk, rst, blk_push.push && full && !pop, "push into full queue")
  `ASSERT_NEVER(a_no_pop_empty, clk, rst, pop && !q_valid, "pop from empty queue")
  `ASSERT_NEVER(a_count_bound, clk, rst, count > CNT_BITS'(zlq_pkg::QUEUE_DEPTH), "count overflow")

endmodule

/* hw/rtl/zlq_back.sv */
// Byte emitter: unpacks one queued block into four output bytes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module zlq_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  logic [zlq_pkg::BLOCK_BITS-1:0] q_word,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     packed_byte,
  output logic                           last_of_block
);

  logic                              busy;
  logic [zlq_pkg::BLOCK_BITS-1:0]    blk;
  logic [zlq_pkg::BYTE_IDX_BITS-1:0] byte_idx;
  logic                              out_xfer;
  logic                              at_last;

  assign at_last       = (byte_idx == zlq_pkg::LAST_BYTE);
  assign out_valid     = busy;
  assign packed_byte   = blk[byte_idx*8 +: 8];
  assign last_of_block = at_last;
  assign out_xfer      = busy && out_ready;
  assign pop           = q_valid && (!busy || (out_xfer && at_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      byte_idx <= '0;
    end else begin
      priority if (pop) begin
        busy     <= 1'b1;
        byte_idx <= '0;
      end else if (out_xfer) begin
        byte_idx <= byte_idx + 1'b1;
        if (at_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      blk <= q_word;
    end
  end

  `ASSERT_CLK(a_wrap_after_last, clk, rst, out_xfer && at_last |=> byte_idx == '0,
              "byte index did not wrap after last byte")
  `ASSERT_CLK(a_hold_on_stall, clk, rst, busy && !out_ready |=> $stable(byte_idx) && busy,
              "emitter advanced while stalled")

endmodule

/* hw/rtl/zigzag_level_quantize_pack_unit.sv */
// Top level of the zigzag 2-bit level quantizer and code packer.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready/coef_value): one signed Q8.8 coefficient
//   per transfer, row-major within each 4x4 block. One transfer per cycle is
//   sustained; in_ready drops only when a block completes while the block
//   queue is full.
//   Output channel (out_valid/out_ready/packed_byte/last_of_block): four bytes
//   per block, four zigzag codes each, first code in bits 1:0; last_of_block
//   marks the fourth byte.
//   Config port (cfg_we/cfg_index/cfg_data): writes level_0..level_3, chosen
//   by cfg_index; write only while the block is idle.
//   The sixteenth coefficient of a block passes the quantizer stage register,
//   the block queue and the emitter register before the block's first byte
//   is valid. Throughput: one coefficient per cycle while the queue has room,
//   set by the two-stage quantizer; the emitter sends four bytes per block.
//   A two-entry block queue lets the emitter stall for up to two blocks
//   before the input side backs up.
//   Reset (rst, synchronous): levels return to -384/-128/128/384, the block
//   position returns to raster 0 and queued blocks are dropped.
module zigzag_level_quantize_pack_unit #(
  parameter int COEF_BITS = zlq_pkg::COEF_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [zlq_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic signed [zlq_pkg::LEVEL_BITS-1:0] cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COEF_BITS-1:0]           coef_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [7:0]                            packed_byte,
  output logic                                  last_of_block
);

  zlq_pkg::blk_push_t             blk_push;
  logic                           q_full;
  logic                           q_valid;
  logic [zlq_pkg::BLOCK_BITS-1:0] q_word;
  logic                           q_pop;

  // Quantize and collect codes at their zigzag slots.
  zlq_front #(
    .COEF_BITS(COEF_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .coef_value (coef_value),
    .q_full     (q_full),
    .blk_push   (blk_push)
  );

  // Hold finished blocks so either side can stall alone.
  zlq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .blk_push (blk_push),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .pop      (q_pop)
  );

  // Emit four bytes per block.
  zlq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_word        (q_word),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .packed_byte   (packed_byte),
    .last_of_block (last_of_block)
  );

endmodule

/* tb/sv/zigzag_level_quantize_pack_checker.sv */
// Checker: watches both channels and the level writes, predicts the packed bytes, compares.
`timescale 1ns / 1ps
module zigzag_level_quantize_pack_checker
  import zlq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic signed [LEVEL_BITS-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [15:0]           coef_value,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [7:0]                   packed_byte,
  input  logic                         last_of_block,
  output int                           mismatch_count,
  output int                           bytes_owed
);

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } block_byte_t;

  // Zigzag slot of each raster position, raster 0 in bits 3:0.
  localparam logic [63:0] ZZ_MAP = {4'd15, 4'd14, 4'd10, 4'd9, 4'd13, 4'd11, 4'd8, 4'd3,
                                    4'd12, 4'd7, 4'd4, 4'd2, 4'd6, 4'd5, 4'd1, 4'd0};

  logic signed [LEVEL_BITS-1:0] level_q [NUM_LEVELS];
  logic [CODE_BITS-1:0]         zz_codes [BLOCK_SIZE];
  logic [ZZ_BITS-1:0]           raster_pos;
  block_byte_t                  owed_q [$];

  initial begin
    mismatch_count = 0;
    bytes_owed     = 0;
  end

  // Two-step search for the bracketing pair; the lower level wins only when strictly nearer.
  function automatic logic [CODE_BITS-1:0] nearest_code(input logic signed [15:0] v);
    int lo;
    int hi;
    int dist_lo;
    int dist_hi;
    lo = 0;
    hi = NUM_LEVELS - 1;
    if (level_q[1] < v) begin
      lo = 1;
      if (level_q[2] < v) lo = 2;
      else hi = 2;
    end else begin
      hi = 1;
    end
    dist_lo = int'(v) - int'(level_q[lo]);
    dist_hi = int'(level_q[hi]) - int'(v);
    return (dist_lo < dist_hi) ? lo[CODE_BITS-1:0] : hi[CODE_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    block_byte_t want;
    logic [7:0]  acc;
    int          errs;
    errs = 0;
    if (rst) begin
      level_q[0] = LEVEL_0_RESET;
      level_q[1] = LEVEL_1_RESET;
      level_q[2] = LEVEL_2_RESET;
      level_q[3] = LEVEL_3_RESET;
      raster_pos = '0;
      owed_q.delete();
    end else begin
      if (cfg_we) level_q[cfg_index] = cfg_data;
      // Compare first so a byte never matches a block that completes at this same edge.
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: byte with none expected: expected nothing, actual byte %02h last %0b",
                   $time, packed_byte, last_of_block);
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (packed_byte !== want.byte_val) begin
            $display("%0t: packed_byte mismatch: expected %02h, actual %02h",
                     $time, want.byte_val, packed_byte);
            errs++;
          end
          if (last_of_block !== want.last) begin
            $display("%0t: last_of_block mismatch: expected %0b, actual %0b",
                     $time, want.last, last_of_block);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        zz_codes[ZZ_MAP[int'(raster_pos) * 4 +: 4]] = nearest_code(coef_value);
        if (raster_pos == LAST_POS) begin
          // Pack four zigzag codes per byte, earliest code in the low bits.
          for (int k = 0; k < BYTES_PER_BLOCK; k++) begin
            for (int j = 0; j < 4; j++) acc[2 * j +: 2] = zz_codes[k * 4 + j];
            want.byte_val = acc;
            want.last     = (k == BYTES_PER_BLOCK - 1);
            owed_q = {owed_q, want};
          end
        end
        raster_pos = raster_pos + 1'b1;
      end
    end
    mismatch_count <= mismatch_count + errs;
    bytes_owed     <= owed_q.size();
  end

endmodule

/* tb/sv/zigzag_level_quantize_pack_unit_test.sv */
// Testbench top: drives coefficient blocks and level writes into the unit and gives the verdict.
`timescale 1ns / 1ps
module zigzag_level_quantize_pack_unit_test;
  import zlq_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 150;
  // Covers the two-stage quantizer plus the queue hop to the emitter register.
  localparam int SETTLE_CYCLES   = 8;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0]    cfg_index = REG_LEVEL_0;
  logic signed [LEVEL_BITS-1:0] cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [15:0]           coef_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [7:0]                   packed_byte;
  logic                         last_of_block;

  int mismatch_count;
  int bytes_owed;

  // Idle percentages per side; the stimulus changes them between phases.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Hold-off handshake: the stimulus bumps the request, the receiver serves it.
  int hold_request = 0;
  int hold_served  = 0;
  int hold_left    = 0;

  int cycle_count = 0;

  // Our copy of the levels, used only to aim random coefficients at them.
  logic signed [LEVEL_BITS-1:0] levels_now [NUM_LEVELS] =
    '{LEVEL_0_RESET, LEVEL_1_RESET, LEVEL_2_RESET, LEVEL_3_RESET};

  always #5 clk = ~clk;

  zigzag_level_quantize_pack_unit #(
    .COEF_BITS(COEF_BITS_DEFAULT)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .coef_value   (coef_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .packed_byte  (packed_byte),
    .last_of_block(last_of_block)
  );

  zigzag_level_quantize_pack_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .coef_value    (coef_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .packed_byte   (packed_byte),
    .last_of_block (last_of_block),
    .mismatch_count(mismatch_count),
    .bytes_owed    (bytes_owed)
  );

  // Receiver: serve a pending hold-off first, otherwise stall at the phase's rate.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_request) begin
      hold_served <= hold_request;
      hold_left   <= HOLD_OFF_CYCLES - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: count cycles and end the run if the stream never drains.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  // Offer one coefficient and hold it until in_ready reads high after an edge. Valid stays high afterwards,
  // so back-to-back items never lower and raise it within one step.
  task automatic send_coef(input logic signed [15:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    coef_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every owed byte is out, then let the pipeline settle.
  task automatic drain_stream();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four levels back to back; only call while the unit is idle.
  task automatic write_levels(input logic signed [15:0] l0, input logic signed [15:0] l1,
                              input logic signed [15:0] l2, input logic signed [15:0] l3);
    logic signed [15:0] vals [NUM_LEVELS];
    vals = '{l0, l1, l2, l3};
    for (int i = 0; i < NUM_LEVELS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_INDEX_BITS-1:0];
      cfg_data  <= vals[i];
      levels_now[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mix of full-range values, values near a level, near-midpoints and exact levels.
  function automatic logic signed [15:0] random_coef();
    int          pick;
    int          i;
    int          j;
    int          val;
    logic [31:0] raw;
    pick = $urandom_range(9);
    i    = $urandom_range(NUM_LEVELS - 1);
    j    = (i + 1) % NUM_LEVELS;
    raw  = $urandom;
    if (pick < 3) return raw[15:0];
    if (pick < 6) val = int'(levels_now[i]) + int'($urandom_range(128)) - 64;
    else if (pick < 8)
      val = ((int'(levels_now[i]) + int'(levels_now[j])) >>> 1) + int'($urandom_range(2)) - 1;
    else val = int'(levels_now[i]);
    if (val > 32767) val = 32767;
    if (val < -32768) val = -32768;
    return val[15:0];
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Phase A: reset levels, sender idles lightly, receiver stalls heavily.
    tx_idle_pct <= 38;
    rx_idle_pct <= 75;
    @(posedge clk);
    // Directed block: field extremes, exact levels, ties and their neighbors.
    send_coef(-32768);  // far below level_0: clamp to code 0
    send_coef(32767);   // far above level_3: clamp to code 3
    send_coef(0);       // tie between level_1 and level_2: upper code
    send_coef(-256);    // tie between level_0 and level_1: upper code
    send_coef(-257);    // one below that tie: lower code
    send_coef(-1);      // one below the middle tie
    send_coef(255);     // one below the top tie
    send_coef(256);     // tie between level_2 and level_3: upper code
    send_coef(-384);
    send_coef(-128);
    send_coef(128);
    send_coef(384);
    send_coef(-385);
    send_coef(385);
    send_coef(1);
    send_coef(-32767);
    for (int n = 0; n < 40; n++) send_coef(random_coef());
    drain_stream();

    // Phase B: levels span the full range, sides swap their idle rates.
    write_levels(-32768, -1, 0, 32767);
    tx_idle_pct <= 75;
    rx_idle_pct <= 38;
    for (int n = 0; n < 56; n++) send_coef(random_coef());
    drain_stream();

    // Phase C: levels out of order, no idling, and one long receiver hold-off so the
    // block queue fills and the input side backs up.
    write_levels(2000, -32768, 32767, -500);
    tx_idle_pct  <= 0;
    rx_idle_pct  <= 0;
    hold_request <= hold_request + 1;
    for (int n = 0; n < 80; n++) send_coef(random_coef());
    drain_stream();

    // Final stretch: random levels in any order, still no idling.
    write_levels(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    for (int n = 0; n < 24; n++) send_coef(random_coef());
    drain_stream();

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/zlq_pkg.sv
hw/rtl/zlq_front.sv
hw/rtl/zlq_queue.sv
hw/rtl/zlq_back.sv
hw/rtl/zigzag_level_quantize_pack_unit.sv
tb/sv/zigzag_level_quantize_pack_checker.sv
tb/sv/zigzag_level_quantize_pack_unit_test.sv
